### hdl/spa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int SLOT_LIMIT = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_ACTIVE_SLOTS = 1'b0;

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_EMPTY          = 3'd1,
    ST_RANGE          = 3'd2,
    ST_DOUBLE_FREE    = 3'd3,
    ST_USE_AFTER_FREE = 3'd4
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
  } rsp_t;

endpackage

### hdl/slot_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit
// Free-list slot allocator: LIFO stack of free indices plus a used bitmap.
// ----------------------------------------------------------------------------
// An item waits in the input register until its result is registered.
// Throughput: one item per cycle unless the result stalls; the two top stack
//   entries live in flops and the stack memory prefetches the third entry
//   down through its registered read port, so a pop or push never waits on it.
// Reset: pool holds all slots, identity stack, bitmap clear. Per-entry valid
//   bits make unwritten stack entries read as their own index; no sweep.
module slot_pool_allocator_unit (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              req_valid,
  output logic                              req_stall,
  input  spa_pkg::req_t                     req_item,
  // result channel
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output spa_pkg::rsp_t                     rsp_item,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [spa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [spa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import spa_pkg::*;

  // --- registers -----------------------------------------------------------
  logic [COUNT_W-1:0]   active_slots;
  logic [COUNT_W-1:0]   free_count, free_count_next;
  // top0 = stack[free_count-1], top1 = stack[free_count-2]
  logic [SLOT_W-1:0]    top0, top0_next;
  logic [SLOT_W-1:0]    top1, top1_next;
  logic [MAX_SLOTS-1:0] used_map, used_map_next;

  // stack memory with per-entry valid bits; invalid entries read as index
  logic [SLOT_W-1:0]    stack_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] stack_valid;
  logic [SLOT_W-1:0]    mem_q;       // registered read data
  logic [SLOT_W-1:0]    rd_addr_q;   // address behind mem_q
  logic                 rd_valid_q;  // valid bit behind mem_q
  logic [SLOT_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]   rd_span;
  logic [SLOT_W-1:0]    below;       // stack[free_count-3]

  // input register
  logic                 item_valid;
  req_t                 item;
  logic                 advance;

  rsp_t                 result;
  logic                 pop, push, do_pop, do_push;

  // register port
  logic                 cfg_hit;
  logic [COUNT_W-1:0]   wr_raw, wr_slots;
  logic [COUNT_W-1:0]   wr_m1, wr_m3;

  // --- handshake -----------------------------------------------------------
  // One item sits in the input register; it moves on when the result
  // register is empty or draining this cycle.
  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;

  // --- register port -------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_hit = psel && penable && pwrite && pready &&
                   (paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_SLOTS);
  assign wr_raw  = pwdata[COUNT_W-1:0];

  always_comb begin
    // clamp into 1..SLOT_LIMIT
    if (wr_raw == '0) begin
      wr_slots = COUNT_W'(1);
    end else if (wr_raw > COUNT_W'(SLOT_LIMIT)) begin
      wr_slots = COUNT_W'(SLOT_LIMIT);
    end else begin
      wr_slots = wr_raw;
    end
    wr_m1 = wr_slots - COUNT_W'(1);
    wr_m3 = wr_slots - COUNT_W'(3);
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_SLOTS) begin
      prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, active_slots};
    end else begin
      prdata = '0;
    end
  end

  // --- stack entry below the cached pair -----------------------------------
  assign below = rd_valid_q ? mem_q : rd_addr_q;

  // --- one item: checks and decision ---------------------------------------
  always_comb begin
    result.granted_slot = '0;
    result.status       = ST_OK;
    pop  = 1'b0;
    push = 1'b0;
    unique case (item.opcode)
      OP_ACQUIRE: begin
        if (free_count == '0) begin
          result.status = ST_EMPTY;
        end else if (used_map[top0]) begin
          result.status = ST_USE_AFTER_FREE;
        end else begin
          pop                 = 1'b1;
          result.granted_slot = top0;
        end
      end
      OP_RELEASE: begin
        // order matters: range, full stack, used mark
        if ({1'b0, item.slot_index} >= active_slots) begin
          result.status = ST_RANGE;
        end else if (free_count >= active_slots) begin
          result.status = ST_DOUBLE_FREE;
        end else if (!used_map[item.slot_index]) begin
          result.status = ST_DOUBLE_FREE;
        end else begin
          push = 1'b1;
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

  assign do_pop  = advance && pop;
  assign do_push = advance && push;

  always_comb begin
    free_count_next = free_count;
    top0_next       = top0;
    top1_next       = top1;
    used_map_next   = used_map;
    if (do_pop) begin
      free_count_next         = free_count - COUNT_W'(1);
      top0_next               = top1;
      top1_next               = below;
      used_map_next[top0]     = 1'b1;
    end else if (do_push) begin
      free_count_next                 = free_count + COUNT_W'(1);
      top0_next                       = item.slot_index;
      top1_next                       = top0;
      used_map_next[item.slot_index]  = 1'b0;
    end
    // prefetch the entry that becomes top1 on the next pop
    rd_span = free_count_next - COUNT_W'(3);
    rd_addr = rd_span[SLOT_W-1:0];
  end

  // stack[count-2] after a re-init is count-2 (unused when count < 2)
  function automatic logic [SLOT_W-1:0] top0_reinit(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] m2;
    m2 = cnt - COUNT_W'(2);
    return m2[SLOT_W-1:0];
  endfunction

  // --- control state -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= COUNT_W'(SLOT_LIMIT);
      free_count   <= COUNT_W'(SLOT_LIMIT);
      top0         <= SLOT_W'(SLOT_LIMIT - 1);
      top1         <= SLOT_W'(SLOT_LIMIT - 2);
      used_map     <= '0;
      stack_valid  <= '0;
      rd_valid_q   <= 1'b0;
      rd_addr_q    <= SLOT_W'(SLOT_LIMIT - 3);
      item_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (!item_valid || advance) begin
        item_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_hit) begin
        // re-initialize: identity stack, clear bitmap, full pool
        active_slots <= wr_slots;
        free_count   <= wr_slots;
        top0         <= wr_m1[SLOT_W-1:0];
        top1         <= top0_reinit(wr_slots);
        used_map     <= '0;
        stack_valid  <= '0;
        rd_valid_q   <= 1'b0;
        rd_addr_q    <= wr_m3[SLOT_W-1:0];
      end else begin
        free_count <= free_count_next;
        top0       <= top0_next;
        top1       <= top1_next;
        used_map   <= used_map_next;
        if (do_push) begin
          stack_valid[free_count[SLOT_W-1:0]] <= 1'b1;
        end
        rd_valid_q <= stack_valid[rd_addr];
        rd_addr_q  <= rd_addr;
      end
    end
  end

  // --- stack memory --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[free_count[SLOT_W-1:0]] <= item.slot_index;
    end
    mem_q <= stack_mem[rd_addr];
  end

  // --- payload registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!item_valid || advance) begin
      item <= req_item;
    end
    if (advance) begin
      rsp_item <= result;
    end
  end

endmodule

### hdl/spa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks for the slot pool allocator, bound into slot_pool_allocator_unit.
// ----------------------------------------------------------------------------
module spa_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input spa_pkg::rsp_t rsp_item
);
  import spa_pkg::*;

  logic rsp_take;
  assign rsp_take = rsp_valid && !rsp_stall;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) (!rst && $past(rst)) |-> !rsp_valid)
    else $error("result valid right after reset");

  // a failed request never hands out a slot
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.status != ST_OK) |-> (rsp_item.granted_slot == '0))
    else $error("failed request carries a granted slot");

  // two nonzero-slot grants in a row, with no release between, are distinct slots
  a_distinct_grants: assert property (@(posedge clk) disable iff (rst)
    (rsp_take && rsp_item.status == ST_OK && rsp_item.granted_slot != '0)
    ##1 (rsp_take && rsp_item.status == ST_OK && rsp_item.granted_slot != '0)
    |-> (rsp_item.granted_slot != $past(rsp_item.granted_slot)))
    else $error("same slot granted twice in a row");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
    else $error("stalled result changed");

endmodule

bind slot_pool_allocator_unit spa_checker u_spa_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

### bench/spa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_scoreboard
// Watches the request, result and register channels of the slot pool
// allocator, tracks its own copy of the pool and checks every result.
// ----------------------------------------------------------------------------
module spa_scoreboard
  import spa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req_item,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);

  logic [COUNT_W-1:0] pool_size;
  logic [COUNT_W-1:0] avail_cnt;
  logic [SLOT_W-1:0]  free_stack [MAX_SLOTS];
  logic               in_use     [MAX_SLOTS];
  rsp_t               owed_rsp_q [$];

  function automatic void refill_pool(input logic [COUNT_W-1:0] n);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_stack[i] = SLOT_W'(i);
      in_use[i]     = 1'b0;
    end
    pool_size = n;
    avail_cnt = n;
  endfunction

  // register write: 0 reads as 1, anything past the limit as the limit
  function automatic logic [COUNT_W-1:0] clamp_slots(input logic [CFG_DATA_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = v[COUNT_W-1:0];
    if (n == '0) n = COUNT_W'(1);
    if (n > COUNT_W'(SLOT_LIMIT)) n = COUNT_W'(SLOT_LIMIT);
    return n;
  endfunction

  function automatic rsp_t serve_request(input req_t rq);
    rsp_t               r;
    logic [SLOT_W-1:0]  top;
    logic [COUNT_W-1:0] top_pos;
    r.granted_slot = '0;
    r.status       = ST_OK;
    if (rq.opcode == OP_ACQUIRE) begin
      if (avail_cnt == '0) begin
        r.status = ST_EMPTY;
      end else begin
        top_pos = avail_cnt - COUNT_W'(1);
        top     = free_stack[top_pos[SLOT_W-1:0]];
        if (in_use[top]) begin
          r.status = ST_USE_AFTER_FREE;
        end else begin
          in_use[top]    = 1'b1;
          avail_cnt      = avail_cnt - COUNT_W'(1);
          r.granted_slot = top;
        end
      end
    end else begin
      // range, then full stack, then used mark
      if (COUNT_W'(rq.slot_index) >= pool_size) begin
        r.status = ST_RANGE;
      end else if (avail_cnt >= pool_size) begin
        r.status = ST_DOUBLE_FREE;
      end else if (!in_use[rq.slot_index]) begin
        r.status = ST_DOUBLE_FREE;
      end else begin
        in_use[rq.slot_index]               = 1'b0;
        free_stack[avail_cnt[SLOT_W-1:0]]   = rq.slot_index;
        avail_cnt                           = avail_cnt + COUNT_W'(1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      refill_pool(COUNT_W'(SLOT_LIMIT));
      owed_rsp_q.delete();
      errors = 0;
    end else begin
      // a result always leaves after its item was taken, so check it first
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing owed: expected none, got slot %0d status %0d",
                   $time, rsp_item.granted_slot, rsp_item.status);
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_item.granted_slot !== want.granted_slot) begin
            errors++;
            $display("%0t: granted_slot expected %0d, got %0d",
                     $time, want.granted_slot, rsp_item.granted_slot);
          end
          if (rsp_item.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, rsp_item.status);
          end
        end
      end
      if (req_valid && !req_stall) owed_rsp_q.push_back(serve_request(req_item));
      if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_SLOTS)
        refill_pool(clamp_slots(pwdata));
    end
    pending = owed_rsp_q.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the slot pool allocator: directed corner items, then random
// acquire/release traffic over several pool sizes with idle bursts on both
// channels and one long result hold-off. Checking lives in spa_scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import spa_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req_item  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp_item;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;

  // idle knobs for the sender and the receiver (percent per item/cycle)
  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_long = 1'b0;  // asks the receiver for one long hold-off

  always #2 clk = ~clk;

  // synchronous reset, asserted from the start, never again
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  slot_pool_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  spa_scoreboard u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .pending   (pending)
  );

  // Offer one item and hold it until the edge that takes it. valid stays up
  // into the next item unless a random gap drops it.
  task automatic send_item(input op_t op, input logic [SLOT_W-1:0] idx);
    req_valid <= 1'b1;
    req_item  <= '{opcode: op, slot_index: idx};
    do @(posedge clk); while (req_stall);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain, then rewrite active_slots (two-phase write). The write rebuilds
  // the pool, so nothing may be in flight.
  task automatic set_pool(input logic [CFG_DATA_W-1:0] n);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);  // margin after the drain
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_SLOTS, 2'b00};
    pwdata  <= n;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stall bursts, plus the one long
  // hold-off that lets the block back up into its request side.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        rsp_stall <= 1'b1;
        repeat (150) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned sizes [9];
    int unsigned eff;
    int unsigned acq_pct;
    int unsigned r;

    sizes = '{64, 1, 2, 0, 127, 100, 0, 5, 64};
    sizes[6] = $urandom_range(1, 64);

    do @(posedge clk); while (rst);

    // --- directed: full pool after reset (64 slots) ---
    gap_pct   = 20;
    stall_pct = 20;
    send_item(OP_RELEASE, 6'd0);    // stack full: double free
    send_item(OP_RELEASE, 6'd63);   // stack full: double free
    send_item(OP_ACQUIRE, 6'd63);   // top of identity stack: 63
    send_item(OP_ACQUIRE, 6'd0);    // then 62
    send_item(OP_RELEASE, 6'd61);   // never handed out: double free
    send_item(OP_RELEASE, 6'd63);   // ok
    send_item(OP_RELEASE, 6'd63);   // freed twice: double free
    send_item(OP_RELEASE, 6'd62);   // ok, pool full again
    send_item(OP_ACQUIRE, 6'd42);   // LIFO: 62 comes back first
    send_item(OP_RELEASE, 6'd62);

    // written zero means one slot
    set_pool(0);
    send_item(OP_ACQUIRE, 6'd0);    // slot 0
    send_item(OP_ACQUIRE, 6'd63);   // empty pool
    send_item(OP_RELEASE, 6'd1);    // past the pool: range
    send_item(OP_RELEASE, 6'd63);   // range
    send_item(OP_RELEASE, 6'd0);    // ok
    send_item(OP_RELEASE, 6'd0);    // full again: double free

    // oversize value clamps to the limit
    set_pool(127);
    send_item(OP_ACQUIRE, 6'd21);   // 63
    send_item(OP_ACQUIRE, 6'd0);    // 62
    send_item(OP_RELEASE, 6'd63);
    send_item(OP_RELEASE, 6'd62);

    // --- random phases over several pool sizes ---
    for (int p = 0; p < 9; p++) begin
      set_pool(sizes[p]);
      eff = (sizes[p] == 0) ? 1 : (sizes[p] > SLOT_LIMIT) ? SLOT_LIMIT : sizes[p];
      // phase 2 runs with no idling at all, the last phase too
      gap_pct   = (p == 2 || p == 8) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 2 || p == 8) ? 0 : $urandom_range(5, 40);
      acq_pct   = 50;
      for (int i = 0; i < 230; i++) begin
        // swing between draining and refilling so both ends get hit
        if (i % 40 == 0) acq_pct = $urandom_range(15, 85);
        // long hold-off early on, sender keeps offering back to back
        if (p == 0 && i == 40) begin
          gap_pct   = 0;
          hold_long = 1'b1;
        end
        if (p == 0 && i == 120) gap_pct = 20;
        r = $urandom_range(0, 99);
        if (r < acq_pct)
          send_item(OP_ACQUIRE, SLOT_W'($urandom));
        else if (r < 94)
          send_item(OP_RELEASE, SLOT_W'($urandom_range(0, eff - 1)));
        else
          send_item(OP_RELEASE, SLOT_W'($urandom));  // often out of range
      end
    end

    // --- wind down and report ---
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### slot_pool_allocator_unit.f
hdl/spa_pkg.sv
hdl/slot_pool_allocator_unit.sv
hdl/spa_checker.sv
bench/spa_checker.sv
bench/tb.sv
